// ===== hw/rtl/sliding_window_min_max_unit_assert.svh =====
// ----------------------------------------------------------------------------
// sliding window min/max unit assertion macros
// shared concurrent assertion forms used by the rtl
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_UNIT_ASSERT_SVH

// same-cycle implication
`define SWMM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SWMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/swmm_pkg.sv =====
// ----------------------------------------------------------------------------
// swmm_pkg
// shared constants and types of the sliding window min/max unit
// ----------------------------------------------------------------------------
package swmm_pkg;

   localparam int SAMPLE_W           = 32;
   localparam int CFG_W              = 7;
   localparam int DEFAULT_WINDOW_MAX = 64;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(1);

   // deque engine sequencer states
   typedef enum logic [2:0] {
      DQ_IDLE,
      DQ_EXPIRE,
      DQ_FRONT_LOAD,
      DQ_BACK_CMP,
      DQ_PUSH
   } swmm_deq_state_type;

   // command from the back-end controller to a deque engine
   typedef struct packed {
      logic start;
      logic last;
   } swmm_eng_ctl_type;

endpackage

// ===== hw/rtl/swmm_if.sv =====
// ----------------------------------------------------------------------------
// swmm channel interfaces
// sample, result and window register channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface swmm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [swmm_pkg::SAMPLE_W-1:0] sample;
   logic                                 sequence_end;

   modport source (output valid, output sample, output sequence_end, input ready);
   modport sink   (input valid, input sample, input sequence_end, output ready);
endinterface

interface swmm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [swmm_pkg::SAMPLE_W-1:0] window_min;
   logic signed [swmm_pkg::SAMPLE_W-1:0] window_max;
   logic                                 last_of_sequence;

   modport source (output valid, output window_min, output window_max,
                   output last_of_sequence, input ready);
   modport sink   (input valid, input window_min, input window_max,
                   input last_of_sequence, output ready);
endinterface

interface swmm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [swmm_pkg::CFG_W-1:0]        window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

// ===== hw/rtl/swmm_ram.sv =====
// ----------------------------------------------------------------------------
// swmm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module swmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/swmm_queue.sv =====
// ----------------------------------------------------------------------------
// swmm_queue
// small fifo decoupling the classifier from the deque engines
// ----------------------------------------------------------------------------
module swmm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == CW'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/swmm_front.sv =====
// ----------------------------------------------------------------------------
// swmm_front
// accepts samples, tags them with position and window, decides on a result
// ----------------------------------------------------------------------------
module swmm_front #(
   parameter int WINDOW_MAX = swmm_pkg::DEFAULT_WINDOW_MAX
) (
   input  logic                                        clock,
   input  logic                                        reset,
   swmm_req_if.sink                                    req_chan,
   input  logic [swmm_pkg::CFG_W-1:0]                  window_size,
   input  logic                                        q_full,
   output logic                                        q_push,
   output logic signed [swmm_pkg::SAMPLE_W-1:0]        q_sample,
   output logic [$clog2(WINDOW_MAX)+1-1:0]             q_pos,
   output logic [$clog2(WINDOW_MAX+1)-1:0]             q_win,
   output logic                                        q_emit,
   output logic                                        q_last
);

   localparam int POS_W = $clog2(WINDOW_MAX) + 1;
   localparam int WIN_W = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W = (swmm_pkg::CFG_W > WIN_W) ? swmm_pkg::CFG_W : WIN_W;

   logic [POS_W-1:0] position_ff, position_in;
   logic [WIN_W-1:0] fill_ff, fill_in;
   logic [WIN_W-1:0] fill_sat;
   logic [CMP_W-1:0] cfg_ext, win_full;
   logic             accept;

   // window register zero acts as one, above the maximum acts as the maximum
   assign cfg_ext  = CMP_W'(window_size);
   assign win_full = (cfg_ext == '0) ? CMP_W'(1) :
                     (cfg_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : cfg_ext;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   assign fill_sat = (fill_ff == WIN_W'(WINDOW_MAX)) ? fill_ff : fill_ff + WIN_W'(1);

   assign q_push   = accept;
   assign q_sample = req_chan.sample;
   assign q_pos    = position_ff;
   assign q_win    = WIN_W'(win_full);
   assign q_emit   = (fill_sat >= WIN_W'(win_full));
   assign q_last   = req_chan.sequence_end;

   always_comb begin
      position_in = position_ff;
      fill_in     = fill_ff;
      if (accept) begin
         position_in = req_chan.sequence_end ? '0 : position_ff + POS_W'(1);
         fill_in     = req_chan.sequence_end ? '0 : fill_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         fill_ff     <= '0;
      end else begin
         position_ff <= position_in;
         fill_ff     <= fill_in;
      end
   end

endmodule

// ===== hw/rtl/swmm_deque.sv =====
// ----------------------------------------------------------------------------
// swmm_deque
// one monotonic deque of value and position, ring buffer in ram
// ----------------------------------------------------------------------------
`include "sliding_window_min_max_unit_assert.svh"

module swmm_deque #(
   parameter int WINDOW_MAX = swmm_pkg::DEFAULT_WINDOW_MAX,
   parameter bit KEEP_MIN   = 1'b1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swmm_pkg::swmm_eng_ctl_type           ctl,
   input  logic signed [swmm_pkg::SAMPLE_W-1:0] in_sample,
   input  logic [$clog2(WINDOW_MAX)+1-1:0]      in_pos,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]      in_win,
   output logic                                 busy,
   output logic signed [swmm_pkg::SAMPLE_W-1:0] front_sample
);

   localparam int SW    = swmm_pkg::SAMPLE_W;
   localparam int AW    = $clog2(WINDOW_MAX);
   localparam int POS_W = $clog2(WINDOW_MAX) + 1;
   localparam int WIN_W = $clog2(WINDOW_MAX + 1);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int DW    = SW + POS_W;
   localparam logic [AW:0] WRAP = (AW + 1)'(WINDOW_MAX);

   swmm_pkg::swmm_deq_state_type state_ff, state_in;

   logic [AW-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic signed [SW-1:0]   front_val_ff, front_val_in;
   logic [POS_W-1:0]       front_pos_ff, front_pos_in;
   logic signed [SW-1:0]   key_ff, key_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [WIN_W-1:0]       win_ff, win_in;
   logic                   last_ff, last_in;

   logic                   rd_en, wr_en;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic [DW-1:0]          rd_data, wr_data;
   logic signed [SW-1:0]   rd_val;
   logic [POS_W-1:0]       rd_pos;
   logic [POS_W-1:0]       age;
   logic                   expired, back_drop;

   function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                          input logic [CNT_W-1:0] off);
      logic [AW:0] sum;
      sum = (AW + 1)'(base) + (AW + 1)'(off);
      if (sum >= WRAP) begin
         sum = sum - WRAP;
      end
      return sum[AW-1:0];
   endfunction

   swmm_ram #(
      .WIDTH (DW),
      .DEPTH (WINDOW_MAX)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_val  = rd_data[DW-1:POS_W];
   assign rd_pos  = rd_data[POS_W-1:0];
   assign wr_data = {key_ff, pos_ff};

   // position difference wraps cleanly, ages never reach the counter range
   assign age       = pos_ff - front_pos_ff;
   assign expired   = (count_ff != '0) && (age >= POS_W'(win_ff));
   assign back_drop = KEEP_MIN ? (rd_val >= key_ff) : (rd_val <= key_ff);

   assign busy         = (state_ff != swmm_pkg::DQ_IDLE);
   assign front_sample = front_val_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swmm_pkg::DQ_IDLE: begin
            if (ctl.start) begin
               state_in = swmm_pkg::DQ_EXPIRE;
            end
         end
         swmm_pkg::DQ_EXPIRE: begin
            if (expired) begin
               state_in = (count_ff != CNT_W'(1)) ? swmm_pkg::DQ_FRONT_LOAD
                                                  : swmm_pkg::DQ_EXPIRE;
            end else begin
               state_in = (count_ff != '0) ? swmm_pkg::DQ_BACK_CMP : swmm_pkg::DQ_PUSH;
            end
         end
         swmm_pkg::DQ_FRONT_LOAD: begin
            state_in = swmm_pkg::DQ_EXPIRE;
         end
         swmm_pkg::DQ_BACK_CMP: begin
            if (!(back_drop && count_ff != CNT_W'(1))) begin
               state_in = swmm_pkg::DQ_PUSH;
            end
         end
         swmm_pkg::DQ_PUSH: begin
            state_in = swmm_pkg::DQ_IDLE;
         end
         default: begin
            state_in = swmm_pkg::DQ_IDLE;
         end
      endcase
   end

   // datapath and ram control
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      front_val_in = front_val_ff;
      front_pos_in = front_pos_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      win_in       = win_ff;
      last_in      = last_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      case (state_ff)
         swmm_pkg::DQ_IDLE: begin
            if (ctl.start) begin
               key_in  = in_sample;
               pos_in  = in_pos;
               win_in  = in_win;
               last_in = ctl.last;
            end
         end
         swmm_pkg::DQ_EXPIRE: begin
            if (expired) begin
               head_in  = slot(head_ff, CNT_W'(1));
               count_in = count_ff - CNT_W'(1);
               if (count_ff != CNT_W'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = slot(head_ff, CNT_W'(1));
               end
            end else if (count_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = slot(head_ff, count_ff - CNT_W'(1));
            end
         end
         swmm_pkg::DQ_FRONT_LOAD: begin
            front_val_in = rd_val;
            front_pos_in = rd_pos;
         end
         swmm_pkg::DQ_BACK_CMP: begin
            if (back_drop) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff != CNT_W'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = slot(head_ff, count_ff - CNT_W'(2));
               end
            end
         end
         swmm_pkg::DQ_PUSH: begin
            wr_en    = 1'b1;
            wr_addr  = slot(head_ff, count_ff);
            count_in = count_ff + CNT_W'(1);
            if (count_ff == '0) begin
               front_val_in = key_ff;
               front_pos_in = pos_ff;
            end
            // end of sequence empties the deque, front copy stays for the result
            if (last_ff) begin
               head_in  = '0;
               count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swmm_pkg::DQ_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      front_val_ff <= front_val_in;
      front_pos_ff <= front_pos_in;
      key_ff       <= key_in;
      pos_ff       <= pos_in;
      win_ff       <= win_in;
      last_ff      <= last_in;
   end

   `SWMM_ASSERT_NOW(a_push_has_room, clock, reset, state_ff == swmm_pkg::DQ_PUSH, count_ff < CNT_W'(WINDOW_MAX), "deque full at push")
   `SWMM_ASSERT_NOW(a_back_cmp_nonempty, clock, reset, state_ff == swmm_pkg::DQ_BACK_CMP, count_ff != '0, "back compare on empty deque")
   `SWMM_ASSERT_NEXT(a_push_leaves_entry, clock, reset, state_ff == swmm_pkg::DQ_PUSH && !last_ff, count_ff != '0 && state_ff == swmm_pkg::DQ_IDLE, "push left deque empty")

endmodule

// ===== hw/rtl/sliding_window_min_max_unit.sv =====
// result path: from accept an item passes the queue, the expire check and push in the
//   engines and the result register; a back compare that keeps its entry, each removed
//   back entry and each expired front entry (with a front load for all but the last) add
//   to it, counted in the slower deque engine
// pacing: the next item starts once the current job completes (expire check, push, hand-off);
//   longer while fronts expire, backs are removed or a result waits on the result channel
// reset: synchronous, clears control, empties both deques, window register to 1
// ----------------------------------------------------------------------------
// sliding_window_min_max_unit
// sliding window minimum and maximum over signed samples, monotonic deques
// ----------------------------------------------------------------------------
module sliding_window_min_max_unit #(
   parameter int WINDOW_MAX = swmm_pkg::DEFAULT_WINDOW_MAX
) (
   input  logic       clock,
   input  logic       reset,
   swmm_req_if.sink   req_chan,
   swmm_rsp_if.source rsp_chan,
   swmm_csr_if.sink   csr_chan
);

   localparam int SW    = swmm_pkg::SAMPLE_W;
   localparam int POS_W = $clog2(WINDOW_MAX) + 1;
   localparam int WIN_W = $clog2(WINDOW_MAX + 1);
   localparam int QW    = SW + POS_W + WIN_W + 2;

   // window register; the user writes it only while the unit is idle, the unit does not enforce it
   logic [swmm_pkg::CFG_W-1:0] window_size_ff, window_size_in;

   // front end to queue
   logic                  f_push;
   logic signed [SW-1:0]  f_sample;
   logic [POS_W-1:0]      f_pos;
   logic [WIN_W-1:0]      f_win;
   logic                  f_emit, f_last;
   logic                  q_full, q_empty, q_pop;
   logic [QW-1:0]         q_push_data, q_pop_data;

   // queue head unpacked for the engines
   logic signed [SW-1:0]  b_sample;
   logic [POS_W-1:0]      b_pos;
   logic [WIN_W-1:0]      b_win;
   logic                  b_emit, b_last;

   // back-end control
   logic                  job_ff, job_in;
   logic                  emit_ff, emit_in;
   logic                  last_ff, last_in;
   logic                  start, complete, slot_free;
   logic                  min_busy, max_busy;
   logic signed [SW-1:0]  min_front, max_front;
   swmm_pkg::swmm_eng_ctl_type eng_ctl;

   // result register, parts the engines from the result channel
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]  rsp_min_ff, rsp_min_in;
   logic signed [SW-1:0]  rsp_max_ff, rsp_max_in;
   logic                  rsp_last_ff, rsp_last_in;

   // configuration port, always ready
   assign csr_chan.ready = 1'b1;
   assign window_size_in = csr_chan.valid ? csr_chan.window_size : window_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swmm_pkg::WINDOW_RESET;
      end else begin
         window_size_ff <= window_size_in;
      end
   end

   // front end: tags each item with position, window and whether it yields a result
   swmm_front #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .window_size (window_size_ff),
      .q_full      (q_full),
      .q_push      (f_push),
      .q_sample    (f_sample),
      .q_pos       (f_pos),
      .q_win       (f_win),
      .q_emit      (f_emit),
      .q_last      (f_last)
   );

   assign q_push_data = {f_sample, f_pos, f_win, f_emit, f_last};

   // short queue so the front end keeps taking items while the engines work
   swmm_queue #(
      .WIDTH (QW),
      .DEPTH (swmm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   assign {b_sample, b_pos, b_win, b_emit, b_last} = q_pop_data;

   // a job finishes once both engines are back in idle and, if it yields a result, the result has a place
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign complete  = job_ff && !min_busy && !max_busy && (!emit_ff || slot_free);
   // next job may start in the cycle the current one finishes
   assign start     = !q_empty && (!job_ff || complete);
   assign q_pop     = start;

   assign eng_ctl.start = start;
   assign eng_ctl.last  = b_last;

   always_comb begin
      job_in  = job_ff;
      emit_in = emit_ff;
      last_in = last_ff;
      if (start) begin
         job_in  = 1'b1;
         emit_in = b_emit;
         last_in = b_last;
      end else if (complete) begin
         job_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff <= 1'b0;
      end else begin
         job_ff <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_ff <= emit_in;
      last_ff <= last_in;
   end

   // min deque: drops back entries not below the new sample
   swmm_deque #(
      .WINDOW_MAX (WINDOW_MAX),
      .KEEP_MIN   (1'b1)
   ) u_min_deque (
      .clock        (clock),
      .reset        (reset),
      .ctl          (eng_ctl),
      .in_sample    (b_sample),
      .in_pos       (b_pos),
      .in_win       (b_win),
      .busy         (min_busy),
      .front_sample (min_front)
   );

   // max deque: drops back entries not above the new sample
   swmm_deque #(
      .WINDOW_MAX (WINDOW_MAX),
      .KEEP_MIN   (1'b0)
   ) u_max_deque (
      .clock        (clock),
      .reset        (reset),
      .ctl          (eng_ctl),
      .in_sample    (b_sample),
      .in_pos       (b_pos),
      .in_win       (b_win),
      .busy         (max_busy),
      .front_sample (max_front)
   );

   // result register load and drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_last_in  = rsp_last_ff;
      if (complete && emit_ff) begin
         rsp_valid_in = 1'b1;
         rsp_min_in   = min_front;
         rsp_max_in   = max_front;
         rsp_last_in  = last_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.window_min       = rsp_min_ff;
   assign rsp_chan.window_max       = rsp_max_ff;
   assign rsp_chan.last_of_sequence = rsp_last_ff;

endmodule
